// ----- rtl/pig_pkg.sv -----
`timescale 1ns / 1ps

package pig_pkg;

  // Field widths fixed by the channel definitions.
  localparam int unsigned TERM_W = 5;
  localparam int unsigned NV_W   = 3;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned MAX_RES = 32;
  localparam logic [NV_W-1:0] NV_RESET = 3'd4;

  // Base-3 digit codes of one cube variable.
  localparam logic [1:0] DIG_DASH = 2'd0;
  localparam logic [1:0] DIG_ZERO = 2'd1;
  localparam logic [1:0] DIG_ONE  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // mark the input term in the bitmap
    logic start;      // latch the variable count and reset the scan
    logic step;       // advance to the next cube
    logic take;       // current cube becomes the pending prime
    logic flush;      // send the pending prime as the final result
  } pig_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic prime;      // current cube is a prime implicant
    logic scan_done;  // current cube is the last one
    logic cnt_full;   // result limit reached
    logic pend_v;     // a pending prime is held
    logic out_free;   // the output register can take a result this cycle
    logic map_empty;  // bitmap is all clear
    logic [CNT_W-1:0] count;
  } pig_sts_t;

endpackage

// ----- rtl/pig_in_if.sv -----
`timescale 1ns / 1ps

interface pig_in_if;
  logic valid;
  logic ready;
  logic [pig_pkg::TERM_W-1:0] term;
  logic last;

  modport source (output valid, output term, output last, input ready);
  modport sink (input valid, input term, input last, output ready);
endinterface

// ----- rtl/pig_out_if.sv -----
`timescale 1ns / 1ps

interface pig_out_if;
  logic valid;
  logic ready;
  logic [pig_pkg::TERM_W-1:0] dash_mask;
  logic [pig_pkg::TERM_W-1:0] cube_bits;
  logic last_res;

  modport source (output valid, output dash_mask, output cube_bits, output last_res,
                  input ready);
  modport sink (input valid, input dash_mask, input cube_bits, input last_res,
                output ready);
endinterface

// ----- rtl/pig_cfg_if.sv -----
`timescale 1ns / 1ps

interface pig_cfg_if;
  logic valid;
  logic ready;
  logic [pig_pkg::NV_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/pig_ctrl.sv -----
`timescale 1ns / 1ps

module pig_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  pig_pkg::pig_sts_t sts,
  output pig_pkg::pig_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   take_w;
  logic   blocked_w;

  // A prime is kept unless the limit is reached; keeping it pushes the
  // previous pending prime, which needs room in the output register.
  assign take_w    = sts.prime && !sts.cnt_full;
  assign blocked_w = take_w && sts.pend_v && !sts.out_free;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.start = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!blocked_w) begin
          cmd.step = 1'b1;
          cmd.take = take_w;
          if (sts.scan_done) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/pig_dp.sv -----
`timescale 1ns / 1ps

module pig_dp #(
  parameter int unsigned MAX_VARS = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [pig_pkg::TERM_W-1:0]   in_term,
  input  logic                         cfg_valid,
  input  logic [pig_pkg::NV_W-1:0]     cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pig_pkg::TERM_W-1:0]   out_dash_mask,
  output logic [pig_pkg::TERM_W-1:0]   out_cube_bits,
  output logic                         out_last_res,
  input  pig_pkg::pig_cmd_t            cmd,
  output pig_pkg::pig_sts_t            sts
);

  localparam int unsigned NT = 1 << MAX_VARS;
  localparam logic [pig_pkg::NV_W-1:0] NV_MAX = pig_pkg::NV_W'(MAX_VARS);

  logic [pig_pkg::NV_W-1:0]   num_vars_r;
  logic [pig_pkg::NV_W-1:0]   nv_eff;
  logic [pig_pkg::NV_W-1:0]   nv_r;
  logic [NT-1:0]              present_r;
  logic [1:0]                 dig_r   [MAX_VARS];
  logic [1:0]                 dig_nxt [MAX_VARS];
  logic [pig_pkg::TERM_W-1:0] fmask_in;
  logic [pig_pkg::TERM_W-1:0] fmask_r;
  logic [pig_pkg::TERM_W-1:0] dash_w;
  logic [pig_pkg::TERM_W-1:0] bits_w;
  logic                       prime_w;
  logic                       done_w;
  logic [pig_pkg::TERM_W-1:0] pend_dash_r;
  logic [pig_pkg::TERM_W-1:0] pend_bits_r;
  logic                       pend_v_r;
  logic [pig_pkg::CNT_W-1:0]  count_r;
  logic                       out_v_r;
  logic [pig_pkg::TERM_W-1:0] out_dash_r;
  logic [pig_pkg::TERM_W-1:0] out_bits_r;
  logic                       out_last_r;
  logic                       out_free_w;
  logic                       push_w;

  // True when every minterm of the cube lies in the bitmap.
  function automatic logic is_impl(input logic [pig_pkg::TERM_W-1:0] d,
                                   input logic [pig_pkg::TERM_W-1:0] b,
                                   input logic [pig_pkg::TERM_W-1:0] fm,
                                   input logic [NT-1:0] pres);
    logic ok;
    logic [pig_pkg::TERM_W-1:0] mm;
    ok = 1'b1;
    for (int m = 0; m < NT; m++) begin
      mm = pig_pkg::TERM_W'(m);
      if (((mm & fm) == mm) && ((mm & ~d & fm) == b) && !pres[m]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Effective variable count, clamped to the supported range.
  always_comb begin
    if (num_vars_r == '0) begin
      nv_eff = pig_pkg::NV_W'(1);
    end else if (num_vars_r > NV_MAX) begin
      nv_eff = NV_MAX;
    end else begin
      nv_eff = num_vars_r;
    end
    fmask_in = pig_pkg::TERM_W'((6'd1 << nv_eff) - 6'd1);
  end

  // Decode the digit counters into the current cube.
  always_comb begin
    dash_w = '0;
    bits_w = '0;
    done_w = 1'b1;
    for (int j = 0; j < MAX_VARS; j++) begin
      if (pig_pkg::NV_W'(j) < nv_r) begin
        if (dig_r[j] == pig_pkg::DIG_DASH) dash_w[j] = 1'b1;
        if (dig_r[j] == pig_pkg::DIG_ONE)  bits_w[j] = 1'b1;
        if (dig_r[j] != pig_pkg::DIG_ONE)  done_w = 1'b0;
      end
    end
  end

  // Prime test: an implicant none of whose one-variable expansions is one.
  always_comb begin
    prime_w = is_impl(dash_w, bits_w, fmask_r, present_r);
    for (int j = 0; j < MAX_VARS; j++) begin
      if ((pig_pkg::NV_W'(j) < nv_r) && !dash_w[j]) begin
        if (is_impl(dash_w | (pig_pkg::TERM_W'(1) << j),
                    bits_w & ~(pig_pkg::TERM_W'(1) << j), fmask_r, present_r)) begin
          prime_w = 1'b0;
        end
      end
    end
  end

  // Base-3 increment of the digit counters, least significant variable first.
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int j = 0; j < MAX_VARS; j++) begin
      dig_nxt[j] = dig_r[j];
      if ((pig_pkg::NV_W'(j) < nv_r) && carry) begin
        if (dig_r[j] == pig_pkg::DIG_ONE) begin
          dig_nxt[j] = pig_pkg::DIG_DASH;
        end else begin
          dig_nxt[j] = dig_r[j] + 2'd1;
          carry = 1'b0;
        end
      end
    end
  end

  assign out_free_w = !out_v_r || out_ready;
  assign push_w     = cmd.take && pend_v_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vars_r <= pig_pkg::NV_RESET;
    end else if (cfg_valid) begin
      num_vars_r <= cfg_data;
    end
  end

  // Bitmap, scan counters and pending prime.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      pend_v_r  <= 1'b0;
      count_r   <= '0;
      nv_r      <= pig_pkg::NV_RESET;
      fmask_r   <= '0;
      for (int j = 0; j < MAX_VARS; j++) dig_r[j] <= pig_pkg::DIG_DASH;
    end else begin
      if (cmd.load) begin
        present_r[MAX_VARS'(in_term & fmask_in)] <= 1'b1;
      end
      if (cmd.start) begin
        nv_r     <= nv_eff;
        fmask_r  <= fmask_in;
        pend_v_r <= 1'b0;
        count_r  <= '0;
        for (int j = 0; j < MAX_VARS; j++) dig_r[j] <= pig_pkg::DIG_DASH;
      end
      if (cmd.step) begin
        for (int j = 0; j < MAX_VARS; j++) dig_r[j] <= dig_nxt[j];
      end
      if (cmd.take) begin
        pend_v_r    <= 1'b1;
        pend_dash_r <= dash_w;
        pend_bits_r <= bits_w;
        count_r     <= count_r + pig_pkg::CNT_W'(1);
      end
      if (cmd.flush) begin
        pend_v_r  <= 1'b0;
        present_r <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (push_w || cmd.flush) begin
      out_v_r    <= 1'b1;
      out_dash_r <= pend_dash_r;
      out_bits_r <= pend_bits_r;
      out_last_r <= cmd.flush;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_valid     = out_v_r;
  assign out_dash_mask = out_dash_r;
  assign out_cube_bits = out_bits_r;
  assign out_last_res  = out_last_r;

  assign sts.prime     = prime_w;
  assign sts.scan_done = done_w;
  assign sts.cnt_full  = (count_r >= pig_pkg::CNT_W'(pig_pkg::MAX_RES));
  assign sts.pend_v    = pend_v_r;
  assign sts.out_free  = out_free_w;
  assign sts.map_empty = (present_r == '0);
  assign sts.count     = count_r;

endmodule

// ----- rtl/prime_implicant_generator.sv -----
`timescale 1ns / 1ps

// Channel    Direction  Payload
// in_ch      sink       term, last
// out_ch     source     dash_mask, cube_bits, last_res
// cfg_ch     sink       data (num_vars)
//
// Each term is accepted while idle; a term marked last starts a scan.
// The scan tests one cube per cycle over all 3^n cubes for n variables, then
// sends the final prime; a stalled output holds the scan.
// Reset is synchronous, active low, and clears the bitmap; num_vars is 4.
// Terms are refused while a scan runs; configuration is always accepted.

module prime_implicant_generator #(
  parameter int unsigned MAX_VARS = 5
) (
  input logic clk,
  input logic rst_n,
  pig_in_if.sink    in_ch,
  pig_out_if.source out_ch,
  pig_cfg_if.sink   cfg_ch
);

  pig_pkg::pig_cmd_t cmd;
  pig_pkg::pig_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  // Sequencing.
  pig_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Bitmap, cube scan and result registers.
  pig_dp #(
    .MAX_VARS (MAX_VARS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_term       (in_ch.term),
    .cfg_valid     (cfg_ch.valid),
    .cfg_data      (cfg_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_dash_mask (out_ch.dash_mask),
    .out_cube_bits (out_ch.cube_bits),
    .out_last_res  (out_ch.last_res),
    .cmd           (cmd),
    .sts           (sts)
  );

  // No pending prime is left over when terms are accepted again.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !sts.pend_v)
    else $error("pending prime held while idle");

  // The result count never exceeds the limit.
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    sts.count <= pig_pkg::CNT_W'(pig_pkg::MAX_RES))
    else $error("result count over limit");

  // The bitmap is clear after a solve completes.
  a_map_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> sts.map_empty)
    else $error("bitmap not cleared after solve");

endmodule
